[design/ucn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucn_pkg
// Shared types, constants and lookup functions for the composition
// normaliser: the composition pair table and the expansion table.
// ----------------------------------------------------------------------------
package ucn_pkg;

  localparam int CP_W        = 21;
  localparam int NCOMP       = 67;
  localparam int MAX_RESULTS = 6;
  localparam int MAX_EXP     = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef logic [CP_W-1:0] cp_t;

  // Input and result payloads
  typedef struct packed {
    cp_t  code_point;
    logic word_end;
  } in_item_t;

  typedef struct packed {
    cp_t  out_char;
    logic run_last;
    logic word_done;
  } out_item_t;

  // Result run produced by one input item
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic [MAX_RESULTS-1:0][CP_W-1:0] chars;
    logic                         wend;
  } seq_t;

  // Pending point update
  typedef struct packed {
    logic valid;
    cp_t  ch;
  } pend_t;

  // Expansion of one code point
  typedef struct packed {
    logic [1:0]                   len;
    logic [MAX_EXP-1:0][CP_W-1:0] ch;
  } exp_t;

  typedef struct packed {
    logic hit;
    cp_t  ch;
  } comp_res_t;

  typedef struct packed {
    cp_t base;
    cp_t mark;
    cp_t comp;
  } comp_entry_t;

  // Base, combining mark, precomposed character
  localparam comp_entry_t COMP_TAB [NCOMP] = '{
    '{21'h41, 21'h300, 21'hC0}, '{21'h41, 21'h301, 21'hC1}, '{21'h41, 21'h302, 21'hC2},
    '{21'h41, 21'h303, 21'hC3}, '{21'h41, 21'h308, 21'hC4}, '{21'h41, 21'h30A, 21'hC5},
    '{21'h43, 21'h327, 21'hC7},
    '{21'h45, 21'h300, 21'hC8}, '{21'h45, 21'h301, 21'hC9}, '{21'h45, 21'h302, 21'hCA},
    '{21'h45, 21'h308, 21'hCB},
    '{21'h49, 21'h300, 21'hCC}, '{21'h49, 21'h301, 21'hCD}, '{21'h49, 21'h302, 21'hCE},
    '{21'h49, 21'h308, 21'hCF},
    '{21'h4E, 21'h303, 21'hD1},
    '{21'h4F, 21'h300, 21'hD2}, '{21'h4F, 21'h301, 21'hD3}, '{21'h4F, 21'h302, 21'hD4},
    '{21'h4F, 21'h303, 21'hD5}, '{21'h4F, 21'h308, 21'hD6},
    '{21'h55, 21'h300, 21'hD9}, '{21'h55, 21'h301, 21'hDA}, '{21'h55, 21'h302, 21'hDB},
    '{21'h55, 21'h308, 21'hDC},
    '{21'h59, 21'h301, 21'hDD},
    '{21'h61, 21'h300, 21'hE0}, '{21'h61, 21'h301, 21'hE1}, '{21'h61, 21'h302, 21'hE2},
    '{21'h61, 21'h303, 21'hE3}, '{21'h61, 21'h308, 21'hE4}, '{21'h61, 21'h30A, 21'hE5},
    '{21'h63, 21'h327, 21'hE7},
    '{21'h65, 21'h300, 21'hE8}, '{21'h65, 21'h301, 21'hE9}, '{21'h65, 21'h302, 21'hEA},
    '{21'h65, 21'h308, 21'hEB},
    '{21'h69, 21'h300, 21'hEC}, '{21'h69, 21'h301, 21'hED}, '{21'h69, 21'h302, 21'hEE},
    '{21'h69, 21'h308, 21'hEF},
    '{21'h6E, 21'h303, 21'hF1},
    '{21'h6F, 21'h300, 21'hF2}, '{21'h6F, 21'h301, 21'hF3}, '{21'h6F, 21'h302, 21'hF4},
    '{21'h6F, 21'h303, 21'hF5}, '{21'h6F, 21'h308, 21'hF6},
    '{21'h75, 21'h300, 21'hF9}, '{21'h75, 21'h301, 21'hFA}, '{21'h75, 21'h302, 21'hFB},
    '{21'h75, 21'h308, 21'hFC},
    '{21'h79, 21'h301, 21'hFD}, '{21'h79, 21'h308, 21'hFF},
    '{21'h53, 21'h30C, 21'h160}, '{21'h73, 21'h30C, 21'h161},
    '{21'h5A, 21'h30C, 21'h17D}, '{21'h7A, 21'h30C, 21'h17E},
    '{21'h418, 21'h306, 21'h419}, '{21'h438, 21'h306, 21'h439},
    '{21'h415, 21'h300, 21'h400}, '{21'h435, 21'h300, 21'h450},
    '{21'h415, 21'h308, 21'h401}, '{21'h435, 21'h308, 21'h451},
    '{21'h413, 21'h301, 21'h403}, '{21'h433, 21'h301, 21'h453},
    '{21'h41E, 21'h308, 21'h4E6}, '{21'h43E, 21'h308, 21'h4E7}
  };

  // Pair lookup: entries are distinct, so at most one matches
  function automatic comp_res_t comp_lookup(input cp_t base, input cp_t mark);
    comp_res_t r;
    r = '0;
    for (int j = 0; j < NCOMP; j++) begin
      if (COMP_TAB[j].base == base && COMP_TAB[j].mark == mark) begin
        r.hit = 1'b1;
        r.ch  = r.ch | COMP_TAB[j].comp;
      end
    end
    return r;
  endfunction

  // Expansion of one point; unlisted points map to themselves
  function automatic exp_t expand_point(input cp_t c);
    exp_t e;
    e       = '0;
    e.len   = 2'd1;
    e.ch[0] = c;
    case (c)
      21'h02019: e.ch[0] = 21'h27;
      21'h02010, 21'h02011: e.ch[0] = 21'h2D;
      21'h02103: begin
        e.len = 2'd2; e.ch[0] = 21'hB0; e.ch[1] = 21'h43;
      end
      21'h02109: begin
        e.len = 2'd2; e.ch[0] = 21'hB0; e.ch[1] = 21'h46;
      end
      21'h0FB00: begin
        e.len = 2'd2; e.ch[0] = 21'h66; e.ch[1] = 21'h66;
      end
      21'h0FB01: begin
        e.len = 2'd2; e.ch[0] = 21'h66; e.ch[1] = 21'h69;
      end
      21'h0FB02: begin
        e.len = 2'd2; e.ch[0] = 21'h66; e.ch[1] = 21'h6C;
      end
      21'h0FB03: begin
        e.len = 2'd3; e.ch[0] = 21'h66; e.ch[1] = 21'h66; e.ch[2] = 21'h69;
      end
      21'h0FB04: begin
        e.len = 2'd3; e.ch[0] = 21'h66; e.ch[1] = 21'h66; e.ch[2] = 21'h6C;
      end
      default: ;
    endcase
    return e;
  endfunction

endpackage

[design/ucn_compose.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucn_compose
// Combinational pass for one item: pair lookup against the pending point,
// expansion of the outgoing points and the next pending point.
// ----------------------------------------------------------------------------
module ucn_compose (
  input  ucn_pkg::in_item_t item,
  input  ucn_pkg::pend_t    pend,
  output ucn_pkg::seq_t     seq,
  output ucn_pkg::pend_t    pend_next
);
  import ucn_pkg::*;

  comp_res_t        comp;
  exp_t             exp_a;
  exp_t             exp_b;
  logic             use_a;
  logic             use_b;
  logic [CNT_W-1:0] len_a;
  logic [CNT_W-1:0] len_b;
  logic [CNT_W-1:0] idx_b;
  logic             matched;

  assign comp    = comp_lookup(pend.ch, item.code_point);
  assign matched = pend.valid && comp.hit;
  assign exp_a   = expand_point(pend.ch);
  assign exp_b   = expand_point(item.code_point);

  // Pending point goes out first, the new point follows at word end
  assign use_a = pend.valid && !matched;
  assign use_b = item.word_end && !matched;
  assign len_a = use_a ? CNT_W'(exp_a.len) : '0;
  assign len_b = use_b ? CNT_W'(exp_b.len) : '0;

  // Build the result run
  always_comb begin
    seq      = '0;
    idx_b    = '0;
    seq.wend = item.word_end;
    if (matched) begin
      seq.count    = CNT_W'(1);
      seq.chars[0] = comp.ch;
    end else begin
      seq.count = len_a + len_b;
      for (int i = 0; i < MAX_RESULTS; i++) begin
        idx_b = CNT_W'(i) - len_a;
        if (CNT_W'(i) < len_a) begin
          seq.chars[i] = exp_a.ch[i % MAX_EXP];
        end else if (idx_b < CNT_W'(MAX_EXP)) begin
          seq.chars[i] = exp_b.ch[idx_b[1:0]];
        end
      end
    end
  end

  // Next pending point
  always_comb begin
    pend_next = '0;
    if (!matched && !item.word_end) begin
      pend_next.valid = 1'b1;
      pend_next.ch    = item.code_point;
    end
  end

endmodule

[design/ucn_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucn_emitter
// Holds the result run of one item and hands it out one result per cycle
// through the output register, while out_stall does not hold it.
// ----------------------------------------------------------------------------
module ucn_emitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ucn_pkg::seq_t      seq,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output ucn_pkg::out_item_t out_data
);
  import ucn_pkg::*;

  logic [MAX_RESULTS-1:0][CP_W-1:0] chars;
  logic [CNT_W-1:0]                 rem;
  logic                             wend;
  logic                             move;
  logic                             last;

  // Head moves to the output register when that register is free or drains
  assign move = (rem != '0) && (!out_valid || !out_stall);
  assign last = (rem == CNT_W'(1));
  assign free = (rem == '0) || (move && last);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rem <= seq.count;
      end else if (move) begin
        rem <= rem - CNT_W'(1);
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run storage shifts down one entry per transfer
  always_ff @(posedge clk) begin
    if (load) begin
      chars <= seq.chars;
      wend  <= seq.wend;
    end else if (move) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        chars[i] <= chars[i+1];
      end
    end
    if (move) begin
      out_data.out_char  <= chars[0];
      out_data.run_last  <= last;
      out_data.word_done <= last && wend;
    end
  end

endmodule

[design/unicode_compose_normaliser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_compose_normaliser
// Composes base + combining mark pairs, expands ligatures, degree signs and a
// few punctuation points, holding one pending code point between items.
// ----------------------------------------------------------------------------
//  channel | signals                        | moves
//  in      | in_valid, in_stall, in_data    | one code point + word end flag
//  out     | out_valid, out_stall, out_data | one result code point + flags
//
//  An item is taken into the run buffer; its 0 to 6 results leave one per
//  cycle while out_stall is low, through the output register.
//  A new item is taken in the cycle the last result of the previous run moves
//  out, so single-result items flow every cycle while out_stall is low.
//  in_stall stays high while a run drains, until its last result moves out.
//  Reset clears the pending point, the run count and the output valid flag.
// ----------------------------------------------------------------------------
module unicode_compose_normaliser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ucn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ucn_pkg::out_item_t out_data
);
  import ucn_pkg::*;

  pend_t pend;
  pend_t pend_next;
  seq_t  seq;
  logic  free;
  logic  accept;

  assign accept   = in_valid && free;
  assign in_stall = !free;

  ucn_compose u_compose (
    .item      (in_data),
    .pend      (pend),
    .seq       (seq),
    .pend_next (pend_next)
  );

  // Pending point register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

  ucn_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .seq       (seq),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[design/ucn_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucn_port_checker
// Port-level checks for the composition normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module ucn_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ucn_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ucn_pkg::out_item_t out_data
);
  import ucn_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // End of word only on the last result of a run
  a_word_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.word_done || out_data.run_last))
    else $error("word_done without run_last");

  // A run has no gaps between its results
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.run_last |=> out_valid)
    else $error("gap inside a result run");

  // Output register empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind unicode_compose_normaliser ucn_port_checker u_ucn_port_checker (.*);
